>>> rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RC4 stream cipher block.
// Used by the interfaces, the controller, the datapath and the top level.
package rc4_pkg;

   localparam int BYTE_W        = 8;
   localparam int SBOX_DEPTH    = 256;
   localparam int MAX_KEY_BYTES = 256;

   // request opcodes
   localparam logic OPC_KEY  = 1'b0;
   localparam logic OPC_DATA = 1'b1;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_KSA_RD,
      ST_KSA_MIX,
      ST_KSA_SWAP_A,
      ST_KSA_SWAP_B,
      ST_PRGA_J,
      ST_PRGA_SWAP,
      ST_PRGA_OUT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY_LOAD,
      OP_FILL,
      OP_KSA_READ,
      OP_KSA_MIX,
      OP_KSA_SWAP_A,
      OP_KSA_SWAP_B,
      OP_PRGA_I,
      OP_PRGA_J,
      OP_PRGA_SWAP,
      OP_PRGA_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic k_last;
   } dp_status_type;

endpackage

>>> rtl/rc4_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for RC4 requests and keystream results.
// Depends on rc4_pkg for the byte width.
interface rc4_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [rc4_pkg::BYTE_W-1:0] in_byte;
   logic                       last_key_byte;

   modport source (output valid, output opcode, output in_byte, output last_key_byte,
                   input ready);
   modport sink   (input valid, input opcode, input in_byte, input last_key_byte,
                   output ready);
endinterface

interface rc4_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rc4_pkg::BYTE_W-1:0] out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

>>> rtl/rc4_stream_cipher.sv
`timescale 1ns / 1ps
// RC4 stream cipher top level: joins the sequencer and the datapath.
// Depends on rc4_pkg, rc4_if, rc4_ctrl and rc4_dp.
//
// Requests arrive on req_chan (valid/ready). A key request (opcode 0) stores
// in_byte in the key store and gives no result; bytes past MAX_KEY_BYTES are
// dropped. A key request with last_key_byte set also runs the key schedule,
// with req_chan not ready: an identity fill of all 256 S-box entries, then
// 256 swap steps (read, mix, two swap writes). A data request (opcode 1)
// yields one result on rsp_chan: in_byte XOR the next keystream byte. The
// PRGA_J, PRGA_SWAP and PRGA_OUT states follow acceptance, the result
// register loading in PRGA_OUT, and the next request is taken only once
// back in idle, so data requests do not overlap; the S-box memory, with one
// read and one write port, read for S[i], S[j] and S[t] and written twice
// per byte, sets this pace. After reset the block sweeps all 256 S-box
// entries to the identity before it takes the first request; indices and
// key length start at zero. A result waits in its register while rsp_chan
// is stalled; a new request is still taken and runs until its own result is due, then holds.
module rc4_stream_cipher #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
   input logic       clock,
   input logic       reset,
   rc4_req_if.sink   req_chan,
   rc4_rsp_if.source rsp_chan
);

   rc4_pkg::dp_cmd_type    dp_cmd;
   rc4_pkg::dp_status_type dp_status;

   rc4_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_opcode        (req_chan.opcode),
      .req_last_key_byte (req_chan.last_key_byte),
      .req_ready         (req_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .cmd               (dp_cmd),
      .status            (dp_status)
   );

   rc4_dp #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dp_cmd),
      .status   (dp_status),
      .in_byte  (req_chan.in_byte),
      .out_byte (rsp_chan.out_byte)
   );

endmodule

>>> rtl/rc4_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the RC4 block: S-box init sweep, key schedule and PRGA steps.
// Issues rc4_pkg::dp_cmd_type commands to rc4_dp and owns the result valid flag.
module rc4_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_opcode,
   input  logic                   req_last_key_byte,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rc4_pkg::dp_cmd_type    cmd,
   input  rc4_pkg::dp_status_type status
);

   rc4_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc4_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = rc4_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         rc4_pkg::ST_INIT: begin
            cmd.op = rc4_pkg::OP_FILL;
            if (status.k_last) state_in = rc4_pkg::ST_IDLE;
         end
         rc4_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == rc4_pkg::OPC_DATA) begin
                  cmd.op   = rc4_pkg::OP_PRGA_I;
                  state_in = rc4_pkg::ST_PRGA_J;
               end else begin
                  cmd.op = rc4_pkg::OP_KEY_LOAD;
                  if (req_last_key_byte) state_in = rc4_pkg::ST_FILL;
               end
            end
         end
         rc4_pkg::ST_FILL: begin
            cmd.op = rc4_pkg::OP_FILL;
            if (status.k_last) state_in = rc4_pkg::ST_KSA_RD;
         end
         rc4_pkg::ST_KSA_RD: begin
            cmd.op   = rc4_pkg::OP_KSA_READ;
            state_in = rc4_pkg::ST_KSA_MIX;
         end
         rc4_pkg::ST_KSA_MIX: begin
            cmd.op   = rc4_pkg::OP_KSA_MIX;
            state_in = rc4_pkg::ST_KSA_SWAP_A;
         end
         rc4_pkg::ST_KSA_SWAP_A: begin
            cmd.op   = rc4_pkg::OP_KSA_SWAP_A;
            state_in = rc4_pkg::ST_KSA_SWAP_B;
         end
         rc4_pkg::ST_KSA_SWAP_B: begin
            cmd.op   = rc4_pkg::OP_KSA_SWAP_B;
            state_in = status.k_last ? rc4_pkg::ST_IDLE : rc4_pkg::ST_KSA_RD;
         end
         rc4_pkg::ST_PRGA_J: begin
            cmd.op   = rc4_pkg::OP_PRGA_J;
            state_in = rc4_pkg::ST_PRGA_SWAP;
         end
         rc4_pkg::ST_PRGA_SWAP: begin
            cmd.op   = rc4_pkg::OP_PRGA_SWAP;
            state_in = rc4_pkg::ST_PRGA_OUT;
         end
         rc4_pkg::ST_PRGA_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = rc4_pkg::OP_PRGA_OUT;
               state_in = rc4_pkg::ST_IDLE;
            end
         end
         default: state_in = rc4_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      if (cmd.op == rc4_pkg::OP_PRGA_OUT) rsp_valid_in = 1'b1;
      else if (rsp_ready)                 rsp_valid_in = 1'b0;
      else                                rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rc4_pkg::OP_PRGA_OUT |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_prga_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.op == rc4_pkg::OP_PRGA_I |=> cmd.op == rc4_pkg::OP_PRGA_J)
      else $error("PRGA step sequence broken");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op) == rc4_pkg::OP_PRGA_OUT)
      else $error("result valid raised without a PRGA output step");

endmodule

>>> rtl/rc4_dp.sv
`timescale 1ns / 1ps
// Datapath for the RC4 block: S-box memory, key store, indices and output byte.
// Driven by rc4_ctrl through rc4_pkg::dp_cmd_type.
module rc4_dp #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rc4_pkg::dp_cmd_type         cmd,
   output rc4_pkg::dp_status_type      status,
   input  logic [rc4_pkg::BYTE_W-1:0]  in_byte,
   output logic [rc4_pkg::BYTE_W-1:0]  out_byte
);

   localparam int IdxW    = $clog2(rc4_pkg::SBOX_DEPTH);
   localparam int KeyIdxW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int LenW    = $clog2(MAX_KEY_BYTES + 1);
   localparam int BW      = rc4_pkg::BYTE_W;

   logic [BW-1:0] sbox_mem [rc4_pkg::SBOX_DEPTH];
   logic [BW-1:0] key_mem  [MAX_KEY_BYTES];

   logic [IdxW-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in, t_ff, t_in;
   logic [KeyIdxW-1:0] pos_ff, pos_in;
   logic [LenW-1:0]    len_ff, len_in;
   logic [BW-1:0]      si_ff, si_in, sj_ff, sj_in, byte_ff, byte_in, out_ff, out_in;
   logic [BW-1:0]      sbox_rdata_ff, key_rdata_ff;

   logic            sbox_we, sbox_re, key_we, key_re;
   logic [IdxW-1:0] sbox_waddr, sbox_raddr;
   logic [BW-1:0]   sbox_wdata, ks_sel;
   logic [IdxW-1:0] mix_sum, jp_sum, t_sum;
   logic            pos_wrap;

   always_ff @(posedge clock) begin
      if (sbox_we) sbox_mem[sbox_waddr] <= sbox_wdata;
      if (sbox_re) sbox_rdata_ff <= sbox_mem[sbox_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[len_ff[KeyIdxW-1:0]] <= in_byte;
      if (key_re) key_rdata_ff <= key_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff   <= '0;
         j_ff   <= '0;
         k_ff   <= '0;
         pos_ff <= '0;
         len_ff <= '0;
      end else begin
         i_ff   <= i_in;
         j_ff   <= j_in;
         k_ff   <= k_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      t_ff    <= t_in;
      byte_ff <= byte_in;
      out_ff  <= out_in;
   end

   assign mix_sum  = j_ff + sbox_rdata_ff + key_rdata_ff;
   assign jp_sum   = j_ff + sbox_rdata_ff;
   assign t_sum    = si_ff + sbox_rdata_ff;
   assign pos_wrap = ((LenW+1)'(pos_ff) + (LenW+1)'(1)) >= (LenW+1)'(len_ff);

   // S[t] after both swap writes: the later write to j wins
   always_comb begin
      if (t_ff == j_ff)      ks_sel = si_ff;
      else if (t_ff == i_ff) ks_sel = sj_ff;
      else                   ks_sel = sbox_rdata_ff;
   end

   always_comb begin
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      t_in       = t_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      si_in      = si_ff;
      sj_in      = sj_ff;
      byte_in    = byte_ff;
      out_in     = out_ff;
      sbox_we    = 1'b0;
      sbox_re    = 1'b0;
      key_we     = 1'b0;
      key_re     = 1'b0;
      sbox_waddr = k_ff;
      sbox_raddr = k_ff;
      sbox_wdata = sbox_rdata_ff;
      unique case (cmd.op)
         rc4_pkg::OP_NONE: ;
         rc4_pkg::OP_KEY_LOAD: begin
            // drop bytes beyond the key store
            if (len_ff < LenW'(MAX_KEY_BYTES)) begin
               key_we = 1'b1;
               len_in = len_ff + LenW'(1);
            end
         end
         rc4_pkg::OP_FILL: begin
            sbox_we    = 1'b1;
            sbox_waddr = k_ff;
            sbox_wdata = BW'(k_ff);
            k_in       = k_ff + IdxW'(1);
            j_in       = '0;
         end
         rc4_pkg::OP_KSA_READ: begin
            sbox_re    = 1'b1;
            sbox_raddr = k_ff;
            key_re     = 1'b1;
         end
         rc4_pkg::OP_KSA_MIX: begin
            j_in       = mix_sum;
            si_in      = sbox_rdata_ff;
            sbox_re    = 1'b1;
            sbox_raddr = mix_sum;
         end
         rc4_pkg::OP_KSA_SWAP_A: begin
            sbox_we    = 1'b1;
            sbox_waddr = k_ff;
            sbox_wdata = sbox_rdata_ff;
         end
         rc4_pkg::OP_KSA_SWAP_B: begin
            sbox_we    = 1'b1;
            sbox_waddr = j_ff;
            sbox_wdata = si_ff;
            k_in       = k_ff + IdxW'(1);
            pos_in     = pos_wrap ? '0 : pos_ff + KeyIdxW'(1);
            if (status.k_last) begin
               i_in   = '0;
               j_in   = '0;
               len_in = '0;
               pos_in = '0;
            end
         end
         rc4_pkg::OP_PRGA_I: begin
            i_in       = i_ff + IdxW'(1);
            sbox_re    = 1'b1;
            sbox_raddr = i_ff + IdxW'(1);
            byte_in    = in_byte;
         end
         rc4_pkg::OP_PRGA_J: begin
            si_in      = sbox_rdata_ff;
            j_in       = jp_sum;
            sbox_re    = 1'b1;
            sbox_raddr = jp_sum;
         end
         rc4_pkg::OP_PRGA_SWAP: begin
            sj_in      = sbox_rdata_ff;
            sbox_we    = 1'b1;
            sbox_waddr = i_ff;
            sbox_wdata = sbox_rdata_ff;
            sbox_re    = 1'b1;
            sbox_raddr = t_sum;
            t_in       = t_sum;
         end
         rc4_pkg::OP_PRGA_OUT: begin
            sbox_we    = 1'b1;
            sbox_waddr = j_ff;
            sbox_wdata = si_ff;
            out_in     = byte_ff ^ ks_sel;
         end
         default: ;
      endcase
   end

   assign status.k_last = (k_ff == {IdxW{1'b1}});
   assign out_byte      = out_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LenW'(MAX_KEY_BYTES))
      else $error("key length beyond key store");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff != '0 |-> (LenW+1)'(pos_ff) < (LenW+1)'(len_ff))
      else $error("key position outside loaded key");

   a_ksa_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == rc4_pkg::OP_KSA_SWAP_B && status.k_last)
      |=> (i_ff == '0 && j_ff == '0 && len_ff == '0 && k_ff == '0))
      else $error("indices not cleared after key schedule");

endmodule

>>> tb/sv/rc4_stream_cipher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for rc4_stream_cipher: a directed table, then random key and data runs.
// Depends on rc4_pkg, the rc4_req_if / rc4_rsp_if interfaces and the block itself.
module rc4_stream_cipher_tb;

   localparam int BYTE_W        = rc4_pkg::BYTE_W;
   localparam int SBOX_DEPTH    = rc4_pkg::SBOX_DEPTH;
   localparam int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES;

   localparam int IDLE_PCT     = 18;
   localparam int QUIET_LIMIT  = 6000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 1400;

   typedef struct packed {
      logic             opcode;
      logic [BYTE_W-1:0] in_byte;
      logic             last_key_byte;
      logic             pinned;
      logic [BYTE_W-1:0] cipher;
   } stim_row_type;

   // pinned rows: identity S-box after reset, and the well-known "Key" / "Plaintext" vector
   localparam stim_row_type DIRECTED [24] = '{
      '{rc4_pkg::OPC_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
      '{rc4_pkg::OPC_DATA, 8'hFF, 1'b1, 1'b1, 8'hFA},
      '{rc4_pkg::OPC_DATA, 8'hA5, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'h4B, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'h65, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'h79, 1'b1, 1'b0, 8'h00},
      '{rc4_pkg::OPC_DATA, 8'h50, 1'b0, 1'b1, 8'hBB},
      '{rc4_pkg::OPC_DATA, 8'h6C, 1'b0, 1'b1, 8'hF3},
      '{rc4_pkg::OPC_DATA, 8'h61, 1'b0, 1'b1, 8'h16},
      '{rc4_pkg::OPC_DATA, 8'h69, 1'b0, 1'b1, 8'hE8},
      '{rc4_pkg::OPC_DATA, 8'h6E, 1'b0, 1'b1, 8'hD9},
      '{rc4_pkg::OPC_DATA, 8'h74, 1'b0, 1'b1, 8'h40},
      '{rc4_pkg::OPC_DATA, 8'h65, 1'b0, 1'b1, 8'hAF},
      '{rc4_pkg::OPC_DATA, 8'h78, 1'b0, 1'b1, 8'h0A},
      '{rc4_pkg::OPC_DATA, 8'h74, 1'b0, 1'b1, 8'hD3},
      '{rc4_pkg::OPC_KEY,  8'hFF, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'h00, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_DATA, 8'h3C, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'h80, 1'b1, 1'b0, 8'h00},
      '{rc4_pkg::OPC_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
      '{rc4_pkg::OPC_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{rc4_pkg::OPC_KEY,  8'hFF, 1'b1, 1'b0, 8'h00},
      '{rc4_pkg::OPC_DATA, 8'h55, 1'b0, 1'b0, 8'h00}
   };

   logic clock;
   logic reset;

   rc4_req_if req_chan ();
   rc4_rsp_if rsp_chan ();

   rc4_stream_cipher DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   logic [BYTE_W-1:0] sbox_m [SBOX_DEPTH];
   logic [BYTE_W-1:0] key_m  [MAX_KEY_BYTES];
   logic [BYTE_W-1:0] ptr_i;
   logic [BYTE_W-1:0] ptr_j;
   int unsigned       key_count;

   logic [BYTE_W-1:0] pending_cipher [$];
   bit                pin_active;
   logic [BYTE_W-1:0] pin_value;
   bit                calm_phase;
   int                fail_count;
   int                req_count;
   int                rsp_count;
   int                schedule_count;
   int                quiet_cycles;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void sbox_identity();
      for (int k = 0; k < SBOX_DEPTH; k++) sbox_m[k] = k[BYTE_W-1:0];
   endfunction

   function automatic void swap_sbox(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] t;
      t = sbox_m[a];
      sbox_m[a] = sbox_m[b];
      sbox_m[b] = t;
   endfunction

   // advance the cipher state by one request; return 1 when it yields a cipher byte
   function automatic bit predict_cipher(input logic op, input logic [BYTE_W-1:0] b,
                                         input logic last, output logic [BYTE_W-1:0] cipher);
      int unsigned       len;
      logic [BYTE_W-1:0] jj;
      logic [BYTE_W-1:0] t;
      cipher = '0;
      if (op == rc4_pkg::OPC_KEY) begin
         // drop key bytes past the key store
         if (key_count < MAX_KEY_BYTES) begin
            key_m[key_count] = b;
            key_count++;
         end
         if (last) begin
            len = (key_count < 1) ? 1 : key_count;
            sbox_identity();
            jj = '0;
            for (int k = 0; k < SBOX_DEPTH; k++) begin
               jj = jj + sbox_m[k] + key_m[k % len];
               swap_sbox(k[BYTE_W-1:0], jj);
            end
            ptr_i = '0;
            ptr_j = '0;
            key_count = 0;
         end
         return 1'b0;
      end
      ptr_i = ptr_i + BYTE_W'(1);
      ptr_j = ptr_j + sbox_m[ptr_i];
      swap_sbox(ptr_i, ptr_j);
      t = sbox_m[ptr_i] + sbox_m[ptr_j];
      cipher = b ^ sbox_m[t];
      return 1'b1;
   endfunction

   // call at a rising edge; returns at the edge where the request is taken
   task automatic send_request(input logic op, input logic [BYTE_W-1:0] b, input logic last,
                               input bit pin, input logic [BYTE_W-1:0] pin_byte);
      if (!calm_phase && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      pin_active = pin;
      pin_value  = pin_byte;
      req_chan.valid         <= 1'b1;
      req_chan.opcode        <= op;
      req_chan.in_byte       <= b;
      req_chan.last_key_byte <= last;
      @(negedge clock);
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
   endtask

   // sample between edges: inputs and outputs only move at the rising edge
   always @(negedge clock) begin
      logic [BYTE_W-1:0] due;
      bit                yields;
      if (!reset && req_chan.valid && req_chan.ready) begin
         req_count++;
         if (req_chan.opcode == rc4_pkg::OPC_KEY && req_chan.last_key_byte) schedule_count++;
         yields = predict_cipher(req_chan.opcode, req_chan.in_byte, req_chan.last_key_byte,
                                 due);
         if (yields) pending_cipher.push_back(pin_active ? pin_value : due);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         if (pending_cipher.size() == 0) begin
            $error("out_byte: expected none, actual %02h", rsp_chan.out_byte);
            fail_count++;
         end else begin
            due = pending_cipher.pop_front();
            if (rsp_chan.out_byte !== due) begin
               $error("out_byte: expected %02h, actual %02h", due, rsp_chan.out_byte);
               fail_count++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      int seq;
      int sent;
      int key_len;
      int burst;
      int roll;
      clock                  = 1'b0;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.opcode        = rc4_pkg::OPC_KEY;
      req_chan.in_byte       = '0;
      req_chan.last_key_byte = 1'b0;
      rsp_chan.ready         = 1'b0;
      pin_active             = 1'b0;
      pin_value              = '0;
      calm_phase             = 1'b0;
      fail_count             = 0;
      req_count              = 0;
      rsp_count              = 0;
      schedule_count         = 0;
      quiet_cycles           = 0;
      sbox_identity();
      ptr_i     = '0;
      ptr_j     = '0;
      key_count = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < $size(DIRECTED); r++)
         send_request(DIRECTED[r].opcode, DIRECTED[r].in_byte, DIRECTED[r].last_key_byte,
                      DIRECTED[r].pinned, DIRECTED[r].cipher);

      seq  = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         calm_phase = (sent >= 400 && sent < 650);
         roll = $urandom_range(99);
         if (seq == 3)
            key_len = MAX_KEY_BYTES;
         else if (seq == 9)
            key_len = MAX_KEY_BYTES + 1 + $urandom_range(40);
         else if (roll < 8)
            key_len = $urandom_range(17, 64);
         else
            key_len = $urandom_range(1, 16);

         if (roll >= 90 && seq != 3 && seq != 9) begin
            // unterminated key fragment: stored, S-box left alone
            for (int k = 0; k < key_len; k++)
               send_request(rc4_pkg::OPC_KEY, BYTE_W'($urandom_range(255)), 1'b0, 1'b0, '0);
            sent += key_len;
         end else begin
            if (roll < 80 || seq == 3 || seq == 9) begin
               for (int k = 0; k < key_len; k++)
                  send_request(rc4_pkg::OPC_KEY, BYTE_W'($urandom_range(255)),
                               k == key_len - 1, 1'b0, '0);
               sent += (key_len < MAX_KEY_BYTES) ? key_len : MAX_KEY_BYTES;
            end
            burst = $urandom_range(1, 24);
            for (int d = 0; d < burst; d++)
               send_request(rc4_pkg::OPC_DATA, BYTE_W'($urandom_range(255)),
                            $urandom_range(9) == 0, 1'b0, '0);
            sent += burst;
         end
         seq++;
      end
      calm_phase = 1'b0;
      req_chan.valid <= 1'b0;

      while (pending_cipher.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests with %0d key schedules, including keys of 256 bytes",
               req_count, schedule_count);
      $display("and longer; %0d cipher bytes compared under random source and sink stalls",
               rsp_count);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
